>>> rtl/vtc_pkg.sv
// vtc_pkg: shared types, constants and helper functions for the vfo tuning controller
// no dependencies; every rtl file refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package vtc_pkg;

    // pot converter and channel plan
    localparam int POT_BITS      = 10;
    localparam int STEP_COUNT    = 11;
    localparam int POT_FULL      = 1034;
    localparam int CHAN_POT_SPAN = POT_FULL / STEP_COUNT;
    localparam int STEP_W        = $clog2(STEP_COUNT);

    // field widths
    localparam int FREQ_W   = 28;
    localparam int SPAN_W   = 20;
    localparam int FINE_W   = 16;
    localparam int TICK_W   = 16;
    localparam int OFFSET_W = FINE_W + 1;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // register reset values
    localparam logic [FREQ_W-1:0] BASE_FREQ_RST   = 28'd12486000;
    localparam logic [SPAN_W-1:0] COARSE_SPAN_RST = 20'd102400;
    localparam logic [FINE_W-1:0] FINE_SPAN_RST   = 16'd10240;
    localparam logic [SPAN_W-1:0] STEP_SPACE_RST  = 20'd10000;
    localparam logic [TICK_W-1:0] LONG_PRESS_RST  = 16'd10000;
    localparam logic [TICK_W-1:0] BLINK_RST       = 16'd200;

    // configuration register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_BASE_FREQ   = 3'd0,
        REG_COARSE_SPAN = 3'd1,
        REG_FINE_SPAN   = 3'd2,
        REG_STEP_SPACE  = 3'd3,
        REG_LONG_PRESS  = 3'd4,
        REG_BLINK       = 3'd5
    } reg_idx_t;

    // tuning mode: bit 0 fine, bit 1 continuous
    typedef enum logic [1:0] {
        MODE_STEP_COARSE = 2'd0,
        MODE_STEP_FINE   = 2'd1,
        MODE_CONT_COARSE = 2'd2,
        MODE_CONT_FINE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [FREQ_W-1:0] base_freq_hz;
        logic [SPAN_W-1:0] coarse_span_hz;
        logic [FINE_W-1:0] fine_span_hz;
        logic [SPAN_W-1:0] step_spacing_hz;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] blink_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        logic  led;
    } mode_status_t;

    // channel number from pot position, clamped to the last channel
    function automatic logic [STEP_W-1:0] step_index(input logic [POT_BITS-1:0] pot);
        logic [STEP_W-1:0] idx;
        idx = '0;
        for (int k = 1; k < STEP_COUNT; k++) begin
            if (32'(pot) >= k * CHAN_POT_SPAN) begin
                idx = idx + STEP_W'(1);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vtc_cfg_regs.sv
// vtc_cfg_regs: apb register file holding the tuning configuration
// depends on vtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module vtc_cfg_regs
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output vtc_pkg::cfg_t           cfg
);

    vtc_pkg::cfg_t     cfg_reg;
    vtc_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = vtc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_freq_hz     <= vtc_pkg::BASE_FREQ_RST;
            cfg_reg.coarse_span_hz   <= vtc_pkg::COARSE_SPAN_RST;
            cfg_reg.fine_span_hz     <= vtc_pkg::FINE_SPAN_RST;
            cfg_reg.step_spacing_hz  <= vtc_pkg::STEP_SPACE_RST;
            cfg_reg.long_press_ticks <= vtc_pkg::LONG_PRESS_RST;
            cfg_reg.blink_ticks      <= vtc_pkg::BLINK_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                vtc_pkg::REG_BASE_FREQ:
                    cfg_reg.base_freq_hz <= pwdata[vtc_pkg::FREQ_W-1:0];
                vtc_pkg::REG_COARSE_SPAN:
                    cfg_reg.coarse_span_hz <= pwdata[vtc_pkg::SPAN_W-1:0];
                vtc_pkg::REG_FINE_SPAN:
                    cfg_reg.fine_span_hz <= pwdata[vtc_pkg::FINE_W-1:0];
                vtc_pkg::REG_STEP_SPACE:
                    cfg_reg.step_spacing_hz <= pwdata[vtc_pkg::SPAN_W-1:0];
                vtc_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_ticks <= pwdata[vtc_pkg::TICK_W-1:0];
                vtc_pkg::REG_BLINK:
                    cfg_reg.blink_ticks <= pwdata[vtc_pkg::TICK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            vtc_pkg::REG_BASE_FREQ:   prdata = 32'(cfg_reg.base_freq_hz);
            vtc_pkg::REG_COARSE_SPAN: prdata = 32'(cfg_reg.coarse_span_hz);
            vtc_pkg::REG_FINE_SPAN:   prdata = 32'(cfg_reg.fine_span_hz);
            vtc_pkg::REG_STEP_SPACE:  prdata = 32'(cfg_reg.step_spacing_hz);
            vtc_pkg::REG_LONG_PRESS:  prdata = 32'(cfg_reg.long_press_ticks);
            vtc_pkg::REG_BLINK:       prdata = 32'(cfg_reg.blink_ticks);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/vtc_mode_ctrl.sv
// vtc_mode_ctrl: button press timing, tuning mode register and led blinker
// depends on vtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module vtc_mode_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire logic                 button_level,
    input  wire vtc_pkg::cfg_t        cfg,
    output vtc_pkg::mode_status_t     status
);

    logic [1:0]                  mode_reg, mode_next;
    logic                        prev_button_reg;
    logic                        press_active_reg, press_active_next;
    logic [vtc_pkg::TICK_W-1:0]  press_count_reg, press_count_next;
    logic [vtc_pkg::TICK_W-1:0]  blink_count_reg, blink_count_next;
    logic                        blink_level_reg, blink_level_next;
    logic [vtc_pkg::TICK_W-1:0]  limit;
    logic [vtc_pkg::TICK_W-1:0]  press_inc;
    logic [vtc_pkg::TICK_W-1:0]  blink_inc;
    logic                        led;

    assign limit = (cfg.long_press_ticks == '0) ? vtc_pkg::TICK_W'(1) : cfg.long_press_ticks;
    assign press_inc = (press_count_reg != vtc_pkg::TICK_MAX) ?
                       press_count_reg + vtc_pkg::TICK_W'(1) : press_count_reg;
    assign blink_inc = (blink_count_reg != vtc_pkg::TICK_MAX) ?
                       blink_count_reg + vtc_pkg::TICK_W'(1) : blink_count_reg;

    always_comb
    begin
        mode_next         = mode_reg;
        press_active_next = press_active_reg;
        press_count_next  = press_count_reg;
        blink_count_next  = blink_count_reg;
        blink_level_next  = blink_level_reg;

        // press in progress: long press on limit, short press on release
        if (press_active_reg)
        begin
            press_count_next = press_inc;
            if (press_inc >= limit)
            begin
                if (!mode_reg[0])
                begin
                    mode_next[1] = ~mode_reg[1];
                end
                press_active_next = 1'b0;
            end
            else if (button_level)
            begin
                mode_next[0]      = ~mode_reg[0];
                press_active_next = 1'b0;
            end
        end

        // falling edge starts a new press
        if (prev_button_reg && !button_level)
        begin
            press_active_next = 1'b1;
            press_count_next  = '0;
        end

        // led follows the new mode
        if (!mode_next[0])
        begin
            led = 1'b0;
        end
        else if (mode_next[1])
        begin
            led = 1'b1;
        end
        else
        begin
            if (blink_inc >= cfg.blink_ticks)
            begin
                blink_count_next = '0;
                blink_level_next = ~blink_level_reg;
            end
            else
            begin
                blink_count_next = blink_inc;
            end
            led = blink_level_next;
        end
    end

    assign status.mode = vtc_pkg::mode_t'(mode_next);
    assign status.led  = led;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 2'(vtc_pkg::MODE_STEP_COARSE);
            prev_button_reg  <= 1'b0;
            press_active_reg <= 1'b0;
            press_count_reg  <= '0;
            blink_count_reg  <= '0;
            blink_level_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            prev_button_reg  <= button_level;
            press_active_reg <= press_active_next;
            press_count_reg  <= press_count_next;
            blink_count_reg  <= blink_count_next;
            blink_level_reg  <= blink_level_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vtc_tune_calc.sv
// vtc_tune_calc: pot hysteresis, coarse and fine frequency state, output sum
// depends on vtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module vtc_tune_calc
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire logic [vtc_pkg::POT_BITS-1:0]   pot_sample,
    input  wire vtc_pkg::mode_status_t          status,
    input  wire vtc_pkg::cfg_t                  cfg,
    output logic                                update,
    output logic      [vtc_pkg::FREQ_W-1:0]     freq_sum
);

    localparam int FPROD_W = vtc_pkg::POT_BITS + vtc_pkg::FINE_W;
    localparam int CPROD_W = vtc_pkg::POT_BITS + vtc_pkg::SPAN_W;
    localparam int SPROD_W = vtc_pkg::STEP_W + vtc_pkg::SPAN_W;
    localparam int WIDE_W  = vtc_pkg::FREQ_W + 1;
    localparam int TOTAL_W = vtc_pkg::FREQ_W + 2;

    logic                                 hyst_up_reg;
    logic [vtc_pkg::POT_BITS-1:0]         prev_pot_reg;
    logic [vtc_pkg::FREQ_W-1:0]           coarse_reg, coarse_next;
    logic signed [vtc_pkg::OFFSET_W-1:0]  fine_reg, fine_next;

    logic signed [vtc_pkg::POT_BITS:0]    diff;
    logic                                 apply;
    logic                                 is_fine;
    logic                                 is_cont;
    logic [FPROD_W-1:0]                   fine_prod;
    logic [CPROD_W-1:0]                   coarse_prod;
    logic [SPROD_W-1:0]                   step_prod;
    logic [vtc_pkg::STEP_W-1:0]           step;
    logic signed [vtc_pkg::OFFSET_W-1:0]  fine_calc;
    logic [WIDE_W-1:0]                    cont_sum;
    logic [WIDE_W-1:0]                    step_sum;
    logic signed [TOTAL_W-1:0]            total;

    assign is_fine = status.mode[0];
    assign is_cont = status.mode[1];

    // one count moves only in the current direction
    assign diff  = $signed({1'b0, pot_sample}) - $signed({1'b0, prev_pot_reg});
    assign apply = (diff > 11'sd1) || (diff < -11'sd1) ||
                   (hyst_up_reg ? (diff > 11'sd0) : (diff < 11'sd0));

    assign fine_prod   = FPROD_W'(pot_sample) * FPROD_W'(cfg.fine_span_hz);
    assign coarse_prod = CPROD_W'(pot_sample) * CPROD_W'(cfg.coarse_span_hz);
    assign step        = vtc_pkg::step_index(pot_sample);
    assign step_prod   = SPROD_W'(step) * SPROD_W'(cfg.step_spacing_hz);

    // fine offset centred on the coarse value
    assign fine_calc = $signed({1'b0, fine_prod[FPROD_W-1:vtc_pkg::POT_BITS]}) -
                       $signed({2'b00, cfg.fine_span_hz[vtc_pkg::FINE_W-1:1]});

    assign cont_sum = WIDE_W'(cfg.base_freq_hz) +
                      WIDE_W'(coarse_prod[CPROD_W-1:vtc_pkg::POT_BITS]);
    assign step_sum = WIDE_W'(cfg.base_freq_hz) + WIDE_W'(step_prod);

    always_comb
    begin
        coarse_next = coarse_reg;
        fine_next   = fine_reg;
        if (apply)
        begin
            if (is_fine)
            begin
                fine_next = fine_calc;
            end
            else
            begin
                fine_next = '0;
                if (is_cont)
                begin
                    coarse_next = cont_sum[WIDE_W-1] ? vtc_pkg::FREQ_MAX :
                                  cont_sum[vtc_pkg::FREQ_W-1:0];
                end
                else
                begin
                    coarse_next = step_sum[WIDE_W-1] ? vtc_pkg::FREQ_MAX :
                                  step_sum[vtc_pkg::FREQ_W-1:0];
                end
            end
        end
    end

    assign update = apply;

    // sum of the stored state, clamped to the field range
    assign total = $signed({2'b00, coarse_reg}) + TOTAL_W'(fine_reg);

    always_comb
    begin
        if (total[TOTAL_W-1])
        begin
            freq_sum = '0;
        end
        else if (total[vtc_pkg::FREQ_W])
        begin
            freq_sum = vtc_pkg::FREQ_MAX;
        end
        else
        begin
            freq_sum = total[vtc_pkg::FREQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_up_reg  <= 1'b0;
            prev_pot_reg <= '0;
            coarse_reg   <= vtc_pkg::BASE_FREQ_RST;
            fine_reg     <= '0;
        end
        else if (fire)
        begin
            coarse_reg <= coarse_next;
            fine_reg   <= fine_next;
            if (apply)
            begin
                hyst_up_reg  <= (diff > 11'sd0);
                prev_pot_reg <= pot_sample;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/vfo_tuning_controller.sv
// vfo_tuning_controller: top level of the vfo tuning controller
// depends on vtc_pkg, vtc_cfg_regs, vtc_mode_ctrl, vtc_tune_calc
`timescale 1ns / 1ps
`default_nettype none

// channel     direction  handshake              payload
// ---------   ---------  ---------------------  --------------------------------------
// tick in     in         in_valid / in_stall    button_level, pot_sample
// result out  out        out_valid / out_stall  freq_hz, freq_update, led_on, tuning_mode
// config      in         apb psel/penable       paddr, pwdata, prdata (pready tied high)
//
// one tick transaction per clock cycle sustained while out_stall is low; a result passes
// through the input register, the state update stage and the output register after its
// transaction is accepted; the state update stage (mode, press timer, blinker, pot
// tracking) finishes a tick as it leaves stage 1, so a new tick can follow straight behind it
// reset is asynchronous and active low; no clearing pass, a tick can be accepted as soon
// as reset is released
// a stall on the output only holds the stages behind it once they are full; bubbles
// in the pipe are squeezed out, so in_stall is low whenever out_valid is low

module vfo_tuning_controller
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [4:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,

    // tick input
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              button_level,
    input  wire logic [vtc_pkg::POT_BITS-1:0]      pot_sample,

    // result output
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [vtc_pkg::FREQ_W-1:0]        freq_hz,
    output logic                                   freq_update,
    output logic                                   led_on,
    output logic      [1:0]                        tuning_mode
);

    vtc_pkg::cfg_t          cfg;
    vtc_pkg::mode_status_t  status;
    logic                   update;
    logic [vtc_pkg::FREQ_W-1:0] freq_sum;

    // stage 1: registered input
    logic                           s1_valid_reg;
    logic                           s1_button_reg;
    logic [vtc_pkg::POT_BITS-1:0]   s1_pot_reg;

    // stage 2: flags of a processed tick; its frequency lives in the tuning state
    logic                           mid_valid_reg;
    logic                           mid_update_reg;
    vtc_pkg::mode_status_t          mid_status_reg;

    // stage 3: result register
    logic                           out_valid_reg;
    logic [vtc_pkg::FREQ_W-1:0]     out_freq_reg;
    logic                           out_update_reg;
    vtc_pkg::mode_status_t          out_status_reg;

    logic out_adv;
    logic mid_adv;
    logic s1_adv;
    logic fire;

    // each stage moves when it is empty or the stage ahead moves
    assign out_adv = !out_valid_reg || !out_stall;
    assign mid_adv = !mid_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || mid_adv;
    // tick is processed as it leaves stage 1; tuning state is only touched then, and
    // stage 2 always drains before the next tick can update the state again
    assign fire    = s1_valid_reg && mid_adv;

    assign in_stall = !s1_adv;

    vtc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vtc_mode_ctrl u_mode_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .button_level (s1_button_reg),
        .cfg          (cfg),
        .status       (status)
    );

    vtc_tune_calc u_tune_calc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .pot_sample (s1_pot_reg),
        .status     (status),
        .cfg        (cfg),
        .update     (update),
        .freq_sum   (freq_sum)
    );

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (mid_adv)
            begin
                mid_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_button_reg <= button_level;
            s1_pot_reg    <= pot_sample;
        end
        if (fire)
        begin
            mid_update_reg <= update;
            mid_status_reg <= status;
        end
        if (out_adv && mid_valid_reg)
        begin
            // freq_sum still reflects this tick: the next one cannot update before now
            out_freq_reg   <= freq_sum;
            out_update_reg <= mid_update_reg;
            out_status_reg <= mid_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign freq_hz     = out_freq_reg;
    assign freq_update = out_update_reg;
    assign led_on      = out_status_reg.led;
    assign tuning_mode = out_status_reg.mode;

endmodule

`default_nettype wire

>>> rtl/vtc_checker.sv
// vtc_checker: port level checks of the vfo tuning controller, bound to the top level
// depends on vtc_pkg and vfo_tuning_controller
`timescale 1ns / 1ps
`default_nettype none

module vtc_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [vtc_pkg::FREQ_W-1:0]    freq_hz,
    input wire logic                          freq_update,
    input wire logic                          led_on,
    input wire logic [1:0]                    tuning_mode
);

    logic [vtc_pkg::FREQ_W-1:0] last_freq_reg;
    logic                       seen_reg;

    // last frequency delivered, for the hold check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_freq_reg <= vtc_pkg::BASE_FREQ_RST;
            seen_reg      <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            last_freq_reg <= freq_hz;
            seen_reg      <= 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(freq_hz) && $stable(freq_update)
            && $stable(led_on) && $stable(tuning_mode))
        else $error("stalled result changed");

    // an empty output never blocks the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

    // led is dark in both coarse modes
    a_led_coarse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tuning_mode == 2'(vtc_pkg::MODE_STEP_COARSE) ||
                      tuning_mode == 2'(vtc_pkg::MODE_CONT_COARSE)) |-> !led_on)
        else $error("led lit in coarse mode");

    // led is steady on in continuous fine
    a_led_cont_fine: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tuning_mode == 2'(vtc_pkg::MODE_CONT_FINE) |-> led_on)
        else $error("led dark in continuous fine mode");

    // frequency only moves on an update
    a_freq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg && !freq_update |-> freq_hz == last_freq_reg)
        else $error("frequency changed without update");

endmodule

bind vfo_tuning_controller vtc_checker u_vtc_checker (.*);

`default_nettype wire
